[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hnt_pkg.sv]
`default_nettype none

package hnt_pkg;

    localparam int TABLE_DEPTH = 128;

    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int CHAN_W = 4;
    localparam int SLOT_W = 7;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int HCNT_W = 8;

    localparam int NOTE_NUM = 1 << NOTE_W;
    localparam int TBL_AW   = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [CHAN_W-1:0] chan;
    } entry_t;

    typedef struct packed {
        logic [VEL_W-1:0]  vel;
        logic [CHAN_W-1:0] chan;
    } aux_t;

    typedef struct packed {
        logic              capture;
        logic              insert;
        logic              scan_clr;
        logic              rem_step;
        logic              rem_commit;
        logic              sort_step;
        logic              slot_rd;
        logic              result_load;
        logic              result_slot;
        logic [STAT_W-1:0] result_code;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             note_zero;
        logic             note_held;
        logic             table_full;
        logic             keep_sorted;
        logic             scan_last;
        logic             sort_last;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/hnt_ram.sv]
`default_nettype none

module hnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/hnt_ctrl.sv]
`default_nettype none

module hnt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hnt_pkg::dp_stat_t stat,
    output hnt_pkg::dp_cmd_t       cmd
);

    import hnt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REM_SCAN,
        S_REM_TAIL,
        S_SORT_SCAN,
        S_SORT_TAIL,
        S_SLOT_RD,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] code_reg, code_next;
    logic              slot_sel_reg, slot_sel_next;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        code_next       = code_reg;
        slot_sel_next   = slot_sel_reg;
        cmd.result_code = code_reg;
        cmd.result_slot = slot_sel_reg;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                code_next     = ST_DONE;
                slot_sel_next = 1'b0;
                state_next    = S_DONE;
                unique case (stat.req_type)
                    REQ_NOTE_ON: begin
                        if (stat.note_zero || stat.note_held) begin
                            code_next = ST_IGNORED;
                        end else if (stat.table_full) begin
                            code_next = ST_FULL;
                        end else begin
                            cmd.insert = 1'b1;
                        end
                    end
                    REQ_NOTE_OFF: begin
                        if (stat.note_zero || !stat.note_held) begin
                            code_next = ST_NOT_FOUND;
                        end else begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_REM_SCAN;
                        end
                    end
                    REQ_READ: begin
                        slot_sel_next = 1'b1;
                        cmd.scan_clr  = 1'b1;
                        state_next    = stat.keep_sorted ? S_SORT_SCAN : S_SLOT_RD;
                    end
                    default: begin
                    end
                endcase
            end
            S_REM_SCAN: begin
                cmd.rem_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_REM_TAIL;
                end
            end
            S_REM_TAIL: begin
                cmd.rem_commit = 1'b1;
                state_next     = S_DONE;
            end
            S_SORT_SCAN: begin
                cmd.sort_step = 1'b1;
                if (stat.sort_last) begin
                    state_next = S_SORT_TAIL;
                end
            end
            S_SORT_TAIL: begin
                state_next = S_SLOT_RD;
            end
            S_SLOT_RD: begin
                cmd.slot_rd = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            code_reg     <= ST_DONE;
            slot_sel_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            code_reg     <= code_next;
            slot_sel_reg <= slot_sel_next;
        end
    end

endmodule

`default_nettype wire

[src/hnt_datapath.sv]
`default_nettype none
`include "assert_macros.svh"

module hnt_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire hnt_pkg::dp_cmd_t                cmd,
    output hnt_pkg::dp_stat_t                    stat,
    input  wire logic [hnt_pkg::S_TDATA_W-1:0]   in_data,
    input  wire logic [hnt_pkg::REQ_W-1:0]       in_user,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_wr_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [hnt_pkg::M_TDATA_W-1:0]   out_data
);

    import hnt_pkg::*;

    // captured request
    logic [REQ_W-1:0]  type_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic                keep_sorted_reg;
    logic [NOTE_NUM-1:0] mask_reg;
    logic [CNT_W-1:0]    count_reg;

    // remove scan
    logic [TBL_AW-1:0] scan_idx_reg;
    logic              rd_vld_reg;
    logic [TBL_AW-1:0] rd_pos_reg;
    logic              found_reg;

    // sort sweep
    logic [NOTE_W-1:0] note_idx_reg;
    logic              srt_vld_reg;
    logic [NOTE_W-1:0] srt_note_reg;
    logic [TBL_AW-1:0] wr_pos_reg;

    // result register
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [HCNT_W-1:0] out_count_reg;
    entry_t            out_entry_reg;
    logic              out_slot_valid_reg;

    logic              tbl_wr_en;
    logic [TBL_AW-1:0] tbl_wr_addr;
    entry_t            tbl_wr_data;
    logic              tbl_rd_en;
    logic [TBL_AW-1:0] tbl_rd_addr;
    entry_t            tbl_rd_data;
    aux_t              aux_wr_data;
    aux_t              aux_rd_data;
    logic              slot_hit;
    logic              shift_wr;
    logic              sort_wr;

    assign shift_wr = rd_vld_reg && found_reg;
    assign sort_wr  = srt_vld_reg && mask_reg[srt_note_reg];
    assign slot_hit = CMP_W'(slot_reg) < CMP_W'(count_reg);

    always_comb begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = count_reg[TBL_AW-1:0];
        tbl_wr_data = '{note: note_reg, vel: vel_reg, chan: chan_reg};
        if (cmd.insert) begin
            tbl_wr_en = 1'b1;
        end else if (shift_wr) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = rd_pos_reg - TBL_AW'(1);
            tbl_wr_data = tbl_rd_data;
        end else if (sort_wr) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = wr_pos_reg;
            tbl_wr_data = '{note: srt_note_reg, vel: aux_rd_data.vel, chan: aux_rd_data.chan};
        end
    end

    assign tbl_rd_en   = cmd.rem_step || cmd.slot_rd;
    assign tbl_rd_addr = cmd.slot_rd ? TBL_AW'(slot_reg) : scan_idx_reg;
    assign aux_wr_data = '{vel: vel_reg, chan: chan_reg};

    hnt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // velocity and channel indexed by note number
    hnt_ram #(
        .WIDTH ($bits(aux_t)),
        .DEPTH (NOTE_NUM)
    ) u_aux_ram (
        .aclk    (aclk),
        .wr_en   (cmd.insert),
        .wr_addr (note_reg),
        .wr_data (aux_wr_data),
        .rd_en   (cmd.sort_step),
        .rd_addr (note_idx_reg),
        .rd_data (aux_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg <= in_user;
            note_reg <= in_data[6:0];
            vel_reg  <= in_data[13:7];
            chan_reg <= in_data[17:14];
            slot_reg <= in_data[24:18];
        end
        rd_pos_reg   <= scan_idx_reg;
        srt_note_reg <= note_idx_reg;
        if (cmd.result_load) begin
            out_status_reg     <= cmd.result_code;
            out_count_reg      <= HCNT_W'(count_reg);
            out_slot_valid_reg <= cmd.result_slot && slot_hit;
            out_entry_reg      <= (cmd.result_slot && slot_hit) ? tbl_rd_data : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_sorted_reg <= 1'b0;
            mask_reg        <= '0;
            count_reg       <= '0;
            scan_idx_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            note_idx_reg    <= '0;
            srt_vld_reg     <= 1'b0;
            wr_pos_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                keep_sorted_reg <= cfg_wr_data;
            end
            if (cmd.insert) begin
                mask_reg[note_reg] <= 1'b1;
                count_reg          <= count_reg + CNT_W'(1);
            end else if (cmd.rem_commit) begin
                mask_reg[note_reg] <= 1'b0;
                count_reg          <= count_reg - CNT_W'(1);
            end

            rd_vld_reg  <= cmd.rem_step;
            srt_vld_reg <= cmd.sort_step;

            if (cmd.scan_clr) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                note_idx_reg <= '0;
                wr_pos_reg   <= '0;
            end else begin
                if (cmd.rem_step) begin
                    scan_idx_reg <= scan_idx_reg + TBL_AW'(1);
                end
                if (rd_vld_reg && !found_reg && tbl_rd_data.note == note_reg) begin
                    found_reg <= 1'b1;
                end
                if (cmd.sort_step) begin
                    note_idx_reg <= note_idx_reg + NOTE_W'(1);
                end
                if (sort_wr) begin
                    wr_pos_reg <= wr_pos_reg + TBL_AW'(1);
                end
            end

            if (cmd.result_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.req_type    = type_reg;
        stat.note_zero   = (note_reg == '0);
        stat.note_held   = mask_reg[note_reg];
        stat.table_full  = (count_reg >= CNT_W'(TABLE_DEPTH));
        stat.keep_sorted = keep_sorted_reg;
        stat.scan_last   = (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1));
        stat.sort_last   = (note_idx_reg == NOTE_W'(NOTE_NUM - 1));
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {3'b000, out_slot_valid_reg, out_entry_reg.chan, out_entry_reg.vel,
                        out_entry_reg.note, out_count_reg, out_status_reg};

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "held count above depth")
    `ASSERT_ALWAYS(a_mask_count, $countones(mask_reg) == int'(count_reg), "mask and count disagree")
    `ASSERT_NEXT(a_remove_clears, cmd.rem_commit, !mask_reg[$past(note_reg)], "removed note still held")
    `ASSERT_ALWAYS(a_one_sweep, !(rd_vld_reg && srt_vld_reg), "remove and sort sweeps overlap")

endmodule

`default_nettype wire

[src/held_note_table.sv]
// held_note_table: compacted table of held MIDI notes with a held count.
// s_ channel: one request per transfer; s_tuser carries the request kind
// (note on, note off, read slot), s_tdata the note, velocity, channel, slot.
// m_ channel: one result per request with status, held count and the read slot.
// cfg_wr_en / cfg_wr_data write keep_sorted; write it only while idle.
// Steps per request, from accept to result on m_tvalid:
//   note on, or any request rejected at decode: decode, then the result
//   note off of a held note: decode, then one table read per slot, in order
//   read slot: decode, then the slot read; with keep_sorted set, a sweep over all
//   128 note numbers first rewrites the table in order before the slot is read
// The table RAM has one write and one read port; the sweeps are bound by it.
// s_tready is high only while no request is in work. A finished result sits
// in the output register, so the next request is taken while it waits; a
// request that completes while an earlier result still waits holds until the register frees.
// Reset empties the table and clears keep_sorted at once; no clearing pass.
`default_nettype none

module held_note_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,   // keep_sorted
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [6:0] note_number, [13:7] note_velocity, [17:14] note_channel,
    // [24:18] slot_index
    input  wire logic [31:0] s_tdata,
    input  wire logic [1:0]  s_tuser,       // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] op_status, [9:2] held_count, [16:10] slot_note, [23:17] slot_velocity,
    // [27:24] slot_channel, [28] slot_valid
    output logic      [31:0] m_tdata
);

    import hnt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hnt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hnt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_data     (s_tdata),
        .in_user     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

endmodule

`default_nettype wire

[bench/hnt_checker.sv]
`timescale 1ns / 1ps

module hnt_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               outstanding,
    output int               mismatches
);

    import hnt_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] chan;
        logic [VEL_W-1:0]  vel;
        logic [NOTE_W-1:0] note;
    } note_request_t;

    typedef struct packed {
        logic              slot_valid;
        logic [CHAN_W-1:0] slot_channel;
        logic [VEL_W-1:0]  slot_velocity;
        logic [NOTE_W-1:0] slot_note;
        logic [HCNT_W-1:0] held_count;
        logic [STAT_W-1:0] op_status;
    } table_result_t;

    entry_t        slots [TABLE_DEPTH];
    int            held;
    logic          sorted_mode;
    table_result_t result_q [$];

    task automatic sort_slots();
        entry_t moving;
        int     j;
        for (int i = 1; i < held; i++) begin
            moving = slots[i];
            j = i;
            while (j > 0 && slots[j-1].note > moving.note) begin
                slots[j] = slots[j-1];
                j--;
            end
            slots[j] = moving;
        end
    endtask

    task automatic apply_request(input logic [1:0] kind, input note_request_t req,
                                 output table_result_t res);
        int hit;
        res = '0;
        res.op_status = ST_DONE;
        hit = -1;
        case (kind)
            REQ_NOTE_ON: begin
                for (int i = 0; i < held; i++)
                    if (slots[i].note == req.note)
                        hit = i;
                if (req.note == '0 || hit >= 0) begin
                    res.op_status = ST_IGNORED;
                end else if (held >= TABLE_DEPTH) begin
                    res.op_status = ST_FULL;
                end else begin
                    slots[held] = '{note: req.note, vel: req.vel, chan: req.chan};
                    held++;
                end
            end
            REQ_NOTE_OFF: begin
                for (int i = 0; i < held; i++)
                    if (req.note != '0 && slots[i].note == req.note && hit < 0)
                        hit = i;
                if (hit < 0) begin
                    res.op_status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < held; i++)
                        slots[i] = slots[i+1];
                    held--;
                    slots[held] = '0;
                end
            end
            REQ_READ: begin
                if (sorted_mode)
                    sort_slots();
                if (int'(req.slot) < held) begin
                    res.slot_note     = slots[req.slot].note;
                    res.slot_velocity = slots[req.slot].vel;
                    res.slot_channel  = slots[req.slot].chan;
                    res.slot_valid    = 1'b1;
                end
            end
            default: ;
        endcase
        res.held_count = HCNT_W'(held);
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slots[i] = '0;
            held = 0;
            sorted_mode = 1'b0;
            result_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en)
                sorted_mode = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got = table_result_t'(m_tdata[28:0]);
                if (result_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("op_status", want.op_status, got.op_status);
                    check_field("held_count", want.held_count, got.held_count);
                    check_field("slot_note", want.slot_note, got.slot_note);
                    check_field("slot_velocity", want.slot_velocity, got.slot_velocity);
                    check_field("slot_channel", want.slot_channel, got.slot_channel);
                    check_field("slot_valid", want.slot_valid, got.slot_valid);
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, note_request_t'(s_tdata[24:0]), want);
                result_q.push_back(want);
            end
            outstanding <= result_q.size();
        end
    end

endmodule

[bench/tb_held_note_table.sv]
`timescale 1ns / 1ps

module tb_held_note_table;
    import hnt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 200;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int outstanding;
    int mismatches;
    int quiet_cycles;
    int send_idle_pct;
    int ready_stall_pct;
    int down_count;
    bit note_down [NOTE_NUM];
    int fill_goal [8] = '{40, 127, 127, 127, 12, 90, 0, 70};

    held_note_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    hnt_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(input logic [1:0] kind, input logic [6:0] note,
                         input logic [6:0] vel, input logic [3:0] chan,
                         input logic [6:0] slot);
        if (kind == REQ_NOTE_ON && note != '0 && !note_down[note]) begin
            note_down[note] = 1'b1;
            down_count++;
        end
        if (kind == REQ_NOTE_OFF && note != '0 && note_down[note]) begin
            note_down[note] = 1'b0;
            down_count--;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, slot, chan, vel, note};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_sorted(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_request(input int goal);
        logic [1:0] kind;
        logic [6:0] note;
        logic [6:0] slot;
        int         roll;
        int         lean_on;
        roll    = $urandom_range(99);
        lean_on = (down_count < goal) ? 85 : 15;
        if (roll < 3)
            kind = REQ_UNUSED;
        else if (roll < 25)
            kind = REQ_READ;
        else
            kind = ($urandom_range(99) < lean_on) ? REQ_NOTE_ON : REQ_NOTE_OFF;
        note = 7'($urandom_range(127));
        slot = 7'($urandom_range(127));
        if ($urandom_range(99) < 90) begin
            if (kind == REQ_NOTE_ON && down_count < NOTE_NUM - 1) begin
                do note = 7'($urandom_range(127, 1)); while (note_down[note]);
            end else if (kind == REQ_NOTE_OFF && down_count > 0) begin
                do note = 7'($urandom_range(127, 1)); while (!note_down[note]);
            end
        end
        if (kind == REQ_READ && down_count > 0 && $urandom_range(99) < 85)
            slot = 7'($urandom_range(down_count - 1));
        issue(kind, note, 7'($urandom_range(127)), 4'($urandom_range(15)), slot);
    endtask

    initial begin
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= '0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        down_count      = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_sorted(1'b0);

        // unsorted table: ignores, duplicates, empty and out of range reads
        issue(REQ_NOTE_ON, 7'd0, 7'd5, 4'd3, 7'd0);
        issue(REQ_NOTE_ON, 7'd127, 7'd127, 4'd15, 7'd127);
        issue(REQ_NOTE_ON, 7'd1, 7'd0, 4'd0, 7'd0);
        issue(REQ_NOTE_ON, 7'd64, 7'd64, 4'd8, 7'd0);
        issue(REQ_NOTE_ON, 7'd127, 7'd1, 4'd1, 7'd0);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd0);
        issue(REQ_READ, 7'd127, 7'd127, 4'd15, 7'd2);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd3);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd127);
        issue(REQ_NOTE_OFF, 7'd5, 7'd0, 4'd0, 7'd0);
        issue(REQ_NOTE_OFF, 7'd0, 7'd0, 4'd0, 7'd0);
        issue(REQ_UNUSED, 7'd127, 7'd127, 4'd15, 7'd127);
        issue(REQ_NOTE_OFF, 7'd127, 7'd0, 4'd0, 7'd0);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd0);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd1);
        settle();
        write_sorted(1'b1);

        // sorting on read
        issue(REQ_NOTE_ON, 7'd90, 7'd10, 4'd2, 7'd0);
        issue(REQ_NOTE_ON, 7'd30, 7'd20, 4'd4, 7'd0);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd0);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd3);
        issue(REQ_NOTE_OFF, 7'd1, 7'd0, 4'd0, 7'd0);
        issue(REQ_READ, 7'd0, 7'd0, 4'd0, 7'd0);
        issue(REQ_READ, 7'd127, 7'd127, 4'd15, 7'd127);

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            write_sorted(phase[0]);
            case (phase >> 1)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 85; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 85; end
                default: begin send_idle_pct = 27; ready_stall_pct = 27; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_request(fill_goal[phase]);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/hnt_pkg.sv
src/hnt_ram.sv
src/hnt_ctrl.sv
src/hnt_datapath.sv
src/held_note_table.sv
bench/hnt_checker.sv
bench/tb_held_note_table.sv
